// ===== rtl/oar_pkg.sv =====
// ----------------------------------------------------------------------------
// oar_pkg
// Shared types and codes for the operand address resolver: request and
// result payloads, request type and addressing mode codes, and the control
// word for the address adder.
// ----------------------------------------------------------------------------
package oar_pkg;

  localparam int MEM_ADDR_BITS = 16;

  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_RESOLVE = 2'd1;
  localparam logic [1:0] REQ_SET_PC  = 2'd2;

  localparam logic [3:0] MODE_IMM  = 4'd0;
  localparam logic [3:0] MODE_ZP   = 4'd1;
  localparam logic [3:0] MODE_ABS  = 4'd2;
  localparam logic [3:0] MODE_ZPX  = 4'd3;
  localparam logic [3:0] MODE_ZPY  = 4'd4;
  localparam logic [3:0] MODE_ABSX = 4'd5;
  localparam logic [3:0] MODE_ABSY = 4'd6;
  localparam logic [3:0] MODE_INDX = 4'd7;
  localparam logic [3:0] MODE_INDY = 4'd8;
  localparam logic [3:0] MODE_IND  = 4'd9;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] target_addr;
    logic [7:0]  write_data;
    logic [3:0]  mode;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
  } req_t;

  typedef struct packed {
    logic [15:0] operand_addr;
    logic [15:0] next_pc;
  } res_t;

  typedef struct packed {
    logic [15:0] a;
    logic [7:0]  b;
    logic        page_wrap;
  } agu_op_t;

endpackage

// ===== rtl/operand_address_resolver.sv =====
// ----------------------------------------------------------------------------
// operand_address_resolver
// Byte memory and program counter with 6502 operand address resolution.
// ----------------------------------------------------------------------------
// A request on req_data (req_valid/req_ready) is a byte write, a program
// counter load or an operand resolve. Each request gives one result on
// res_data (res_valid/res_ready): the effective address and the counter
// after the request. One request is handled at a time; req_ready is high
// only while the sequencer is idle.
// The single memory port (one byte read a cycle) and the one shared adder
// set the pace of each request; the next request can be taken at the same
// edge at which the result can first be taken.
// After reset the memory is swept to zero, one byte a cycle, over all
// 2**MEM_ADDR_BITS bytes (65536 at full size); req_ready stays low until
// the sweep ends. The result sits in an output register: a request may be
// accepted while it waits, but the next result is held back until the
// receiver takes the previous one.
// ----------------------------------------------------------------------------
module operand_address_resolver import oar_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req_data,
  output logic res_valid,
  input  logic res_ready,
  output res_t res_data
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_OP_LO,
    S_OP_W,
    S_OP_HI,
    S_OP_W2,
    S_PTR_LO,
    S_PTR_HI,
    S_PTR_W,
    S_FINISH
  } state_t;

  state_t                   state;
  logic [MEM_ADDR_BITS-1:0] clr_addr;
  logic [15:0]              pc;
  logic [15:0]              npc;
  logic [15:0]              ea;
  logic [15:0]              ptr;
  logic [7:0]               lo_byte;
  logic [3:0]               op_mode;
  logic [7:0]               idx_x;
  logic [7:0]               idx_y;

  logic                     ram_we;
  logic [7:0]               ram_wdata;
  logic [MEM_ADDR_BITS-1:0] ram_addr;
  logic [7:0]               ram_rdata;
  logic [15:0]              access_addr;
  agu_op_t                  agu_op;
  logic [15:0]              agu_sum;
  logic                     res_load;

  oar_ram #(
    .ADDR_BITS (MEM_ADDR_BITS),
    .DATA_BITS (8)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  oar_agu u_agu (
    .op  (agu_op),
    .sum (agu_sum)
  );

  assign req_ready = (state == S_IDLE);
  assign res_load  = (state == S_FINISH) && (!res_valid || res_ready);

  always_comb begin
    agu_op.a         = pc;
    agu_op.b         = 8'h00;
    agu_op.page_wrap = 1'b0;
    ram_we           = 1'b0;
    ram_wdata        = req_data.write_data;
    access_addr      = pc;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = 8'h00;
      end
      S_IDLE: begin
        access_addr = req_data.target_addr;
        ram_we      = req_valid && (req_data.req_type == REQ_WRITE);
      end
      S_OP_LO: begin
        agu_op.b = 8'd1;
      end
      S_OP_HI: begin
        access_addr = npc;
        agu_op.b    = 8'd2;
      end
      S_OP_W: begin
        // zero-page operand plus index, kept within page zero
        agu_op.a         = {8'h00, ram_rdata};
        agu_op.page_wrap = 1'b1;
        if (op_mode == MODE_ZPX || op_mode == MODE_INDX) begin
          agu_op.b = idx_x;
        end else if (op_mode == MODE_ZPY) begin
          agu_op.b = idx_y;
        end
      end
      S_OP_W2: begin
        agu_op.a = {ram_rdata, lo_byte};
        if (op_mode == MODE_ABSX) begin
          agu_op.b = idx_x;
        end else if (op_mode == MODE_ABSY) begin
          agu_op.b = idx_y;
        end
      end
      S_PTR_LO: begin
        access_addr      = ptr;
        agu_op.a         = ptr;
        agu_op.b         = 8'd1;
        agu_op.page_wrap = (op_mode != MODE_IND);
      end
      S_PTR_HI: begin
        access_addr = ptr;
      end
      S_PTR_W: begin
        agu_op.a = {ram_rdata, lo_byte};
        if (op_mode == MODE_INDY) begin
          agu_op.b = idx_y;
        end
      end
      default: begin
      end
    endcase
  end

  assign ram_addr = (state == S_CLEAR) ? clr_addr : access_addr[MEM_ADDR_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      pc        <= 16'h0000;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            op_mode <= req_data.mode;
            idx_x   <= req_data.index_x;
            idx_y   <= req_data.index_y;
            ea      <= 16'h0000;
            if (req_data.req_type == REQ_SET_PC) begin
              npc <= req_data.target_addr;
            end else begin
              npc <= pc;
            end
            if (req_data.req_type == REQ_RESOLVE &&
                (req_data.mode inside {[MODE_IMM:MODE_IND]})) begin
              state <= S_OP_LO;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_OP_LO: begin
          npc <= agu_sum;
          ea  <= pc;
          if (op_mode == MODE_IMM) begin
            state <= S_FINISH;
          end else if (op_mode inside {MODE_ABS, MODE_ABSX, MODE_ABSY, MODE_IND}) begin
            state <= S_OP_HI;
          end else begin
            state <= S_OP_W;
          end
        end
        S_OP_W: begin
          if (op_mode == MODE_INDX || op_mode == MODE_INDY) begin
            ptr   <= agu_sum;
            state <= S_PTR_LO;
          end else begin
            ea    <= agu_sum;
            state <= S_FINISH;
          end
        end
        S_OP_HI: begin
          lo_byte <= ram_rdata;
          npc     <= agu_sum;
          state   <= S_OP_W2;
        end
        S_OP_W2: begin
          if (op_mode == MODE_IND) begin
            ptr   <= agu_sum;
            state <= S_PTR_LO;
          end else begin
            ea    <= agu_sum;
            state <= S_FINISH;
          end
        end
        S_PTR_LO: begin
          ptr   <= agu_sum;
          state <= S_PTR_HI;
        end
        S_PTR_HI: begin
          lo_byte <= ram_rdata;
          state   <= S_PTR_W;
        end
        S_PTR_W: begin
          ea    <= agu_sum;
          state <= S_FINISH;
        end
        S_FINISH: begin
          // hold until the output register is free
          if (res_load) begin
            res_data.operand_addr <= ea;
            res_data.next_pc      <= npc;
            pc                    <= npc;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/oar_ram.sv =====
// ----------------------------------------------------------------------------
// oar_ram
// Single-port byte memory with registered read data.
// ----------------------------------------------------------------------------
module oar_ram #(
  parameter int ADDR_BITS = 16,
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [DATA_BITS-1:0] wdata,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/oar_agu.sv =====
// ----------------------------------------------------------------------------
// oar_agu
// Shared address adder: adds a byte to a 16-bit address, optionally
// wrapping the sum within page zero.
// ----------------------------------------------------------------------------
module oar_agu import oar_pkg::*; (
  input  agu_op_t     op,
  output logic [15:0] sum
);

  logic [15:0] full_sum;
  logic [7:0]  page_sum;

  assign full_sum = op.a + {8'h00, op.b};
  assign page_sum = op.a[7:0] + op.b;
  assign sum      = op.page_wrap ? {8'h00, page_sum} : full_sum;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the operand address resolver. A short table of
// directed requests covers every request type, every addressing mode and the
// wrap cases at page zero and the top of memory. It is followed by random
// programs: operand bytes are written at the counter and pointer bytes at the
// pointer, then the operand is resolved. Every result is checked against the
// table's expected value or a local copy of the memory and the program counter.
// ----------------------------------------------------------------------------
module tb_top import oar_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_NONE   = 2'd3;
  localparam logic [3:0] MODE_ACC   = 4'd10;
  localparam logic [3:0] MODE_IMPL  = 4'd11;
  localparam logic [3:0] MODE_SPARE = 4'd15;

  localparam int MEM_DEPTH          = 1 << MEM_ADDR_BITS;
  localparam logic [15:0] ADDR_MASK = 16'(MEM_DEPTH - 1);
  localparam int RANDOM_REQUESTS    = 1700;
  localparam int HOLD_OFF_CYCLES    = 150;
  localparam int DRAIN_CYCLES       = 20;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_data  = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res_data;

  typedef struct {
    req_t req;
    bit   typed;
    res_t want;
  } dir_row_t;

  bit [7:0]  mem_image [MEM_DEPTH];
  bit [15:0] pc_shadow;
  res_t      pending_results[$];
  dir_row_t  dir_rows[$];
  int        err_count      = 0;
  int        requests_taken = 0;
  int        results_seen   = 0;
  int        burst_left     = 0;

  always #1 clk = ~clk;

  operand_address_resolver i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  function automatic logic [7:0] peek_byte(logic [15:0] a);
    return mem_image[a & ADDR_MASK];
  endfunction

  function automatic logic [15:0] peek_word(logic [15:0] a);
    return {peek_byte(a + 16'd1), peek_byte(a)};
  endfunction

  // pointer fetch stays inside page zero
  function automatic logic [15:0] peek_zp_word(logic [7:0] p);
    return {peek_byte({8'h00, p + 8'd1}), peek_byte({8'h00, p})};
  endfunction

  function automatic res_t predict_operand(req_t r);
    res_t        o;
    logic [15:0] pc;
    logic [15:0] ea;
    logic [7:0]  op;
    logic [1:0]  step;
    pc   = pc_shadow;
    ea   = '0;
    step = 2'd0;
    case (r.req_type)
      REQ_WRITE:  mem_image[r.target_addr & ADDR_MASK] = r.write_data;
      REQ_SET_PC: pc = r.target_addr;
      REQ_RESOLVE: begin
        op = peek_byte(pc);
        case (r.mode)
          MODE_IMM:  begin ea = pc;                                  step = 2'd1; end
          MODE_ZP:   begin ea = {8'h00, op};                         step = 2'd1; end
          MODE_ABS:  begin ea = peek_word(pc);                       step = 2'd2; end
          MODE_ZPX:  begin ea = {8'h00, op + r.index_x};             step = 2'd1; end
          MODE_ZPY:  begin ea = {8'h00, op + r.index_y};             step = 2'd1; end
          MODE_ABSX: begin ea = peek_word(pc) + r.index_x;           step = 2'd2; end
          MODE_ABSY: begin ea = peek_word(pc) + r.index_y;           step = 2'd2; end
          MODE_INDX: begin ea = peek_zp_word(op + r.index_x);        step = 2'd1; end
          MODE_INDY: begin ea = peek_zp_word(op) + r.index_y;        step = 2'd1; end
          MODE_IND:  begin ea = peek_word(peek_word(pc));            step = 2'd2; end
          default:   ;
        endcase
        pc = pc + step;
      end
      default: ;
    endcase
    pc_shadow      = pc;
    o.operand_addr = ea;
    o.next_pc      = pc;
    return o;
  endfunction

  function automatic req_t random_request();
    req_t        r;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    r   = raw[$bits(req_t)-1:0];
    return r;
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [15:0] v;
    v = 16'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      case (v[10:8])
        3'd0: v[7:0] = 8'h00;
        3'd1: v[7:0] = 8'hFF;
        3'd2: v[7:0] = 8'h7F;
        3'd3: v[7:0] = 8'h80;
        3'd4: v[7:0] = 8'h01;
        3'd5: v[7:0] = 8'hFE;
        default: ;
      endcase
    end
    return v[7:0];
  endfunction

  // favour page zero, the top page and the boundaries between pages
  function automatic logic [15:0] pick_addr();
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(0, 4))
      0: v[15:8] = 8'h00;
      1: v[15:8] = 8'hFF;
      2: v[15:8] = 8'h01;
      3: begin
        case (v[2:0])
          3'd0: v = 16'h0000;
          3'd1: v = 16'h00FF;
          3'd2: v = 16'h0100;
          3'd3: v = 16'h7FFF;
          3'd4: v = 16'h8000;
          3'd5: v = 16'hFFFE;
          3'd6: v = 16'hFFFF;
          default: v = 16'h01FF;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic void add_row(logic [1:0] kind, logic [15:0] addr, logic [7:0] data,
                                  logic [3:0] md, logic [7:0] x, logic [7:0] y,
                                  bit typed, logic [15:0] ea, logic [15:0] pc);
    dir_row_t row;
    row.req   = '{kind, addr, data, md, x, y};
    row.typed = typed;
    row.want  = '{ea, pc};
    dir_rows.push_back(row);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    err_count++;
  endtask

  // sender works in bursts; a gap drops valid only between requests
  task automatic send_request(input req_t r, input bit typed = 1'b0,
                              input res_t want = '0);
    int   gap;
    res_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      if (gap != 0) begin
        @(negedge clk);
        req_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 200)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    req_valid = 1'b1;
    req_data  = r;
    do @(posedge clk); while (!req_ready);
    predicted = predict_operand(r);
    pending_results.push_back(typed ? want : predicted);
    requests_taken++;
  endtask

  task automatic put_byte(input logic [15:0] addr, input logic [7:0] data);
    req_t r;
    r             = random_request();
    r.req_type    = REQ_WRITE;
    r.target_addr = addr;
    r.write_data  = data;
    send_request(r);
  endtask

  initial begin : stimulus
    req_t        r;
    int          pick;
    logic [3:0]  md;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  p;
    logic [15:0] base;
    logic [15:0] q;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    //      kind         addr      data   mode        x      y      typed ea        pc
    add_row(REQ_RESOLVE, 16'h0000, 8'h00, MODE_IMM,   8'h00, 8'h00, 1, 16'h0000, 16'h0001);
    add_row(REQ_RESOLVE, 16'hFFFF, 8'hFF, MODE_ZP,    8'hFF, 8'hFF, 1, 16'h0000, 16'h0002);
    add_row(REQ_RESOLVE, 16'h0000, 8'h00, MODE_ABS,   8'h00, 8'h00, 1, 16'h0000, 16'h0004);
    add_row(REQ_RESOLVE, 16'h0000, 8'h00, MODE_IND,   8'h00, 8'h00, 1, 16'h0000, 16'h0006);
    add_row(REQ_WRITE,   16'hFFFF, 8'hFF, MODE_SPARE, 8'hFF, 8'hFF, 1, 16'h0000, 16'h0006);
    add_row(REQ_WRITE,   16'h0000, 8'hA5, MODE_IMM,   8'h00, 8'h00, 1, 16'h0000, 16'h0006);
    add_row(REQ_WRITE,   16'h00FF, 8'h34, MODE_IMM,   8'h00, 8'h00, 1, 16'h0000, 16'h0006);
    add_row(REQ_SET_PC,  16'hFFFF, 8'h00, MODE_IMM,   8'h00, 8'h00, 1, 16'h0000, 16'hFFFF);
    // word straddles the top of memory and the counter wraps
    add_row(REQ_RESOLVE, 16'h0000, 8'h00, MODE_ABS,   8'h00, 8'h00, 0, 16'h0000, 16'h0000);
    add_row(REQ_RESOLVE, 16'h0000, 8'h00, MODE_ACC,   8'h12, 8'h34, 1, 16'h0000, 16'h0001);
    add_row(REQ_RESOLVE, 16'hFFFF, 8'hFF, MODE_IMPL,  8'hFF, 8'hFF, 1, 16'h0000, 16'h0001);
    add_row(REQ_RESOLVE, 16'h0000, 8'h00, MODE_SPARE, 8'h00, 8'h00, 1, 16'h0000, 16'h0001);
    add_row(REQ_NONE,    16'h1234, 8'hFF, MODE_SPARE, 8'hFF, 8'hFF, 1, 16'h0000, 16'h0001);
    add_row(REQ_SET_PC,  16'h0100, 8'h00, MODE_IMM,   8'h00, 8'h00, 1, 16'h0000, 16'h0100);
    add_row(REQ_WRITE,   16'h0100, 8'hFF, MODE_IMM,   8'h00, 8'h00, 1, 16'h0000, 16'h0100);
    add_row(REQ_WRITE,   16'h0101, 8'h80, MODE_IMM,   8'h00, 8'h00, 1, 16'h0000, 16'h0100);
    // zero page index wraps within page zero
    add_row(REQ_RESOLVE, 16'h0000, 8'h00, MODE_ZPX,   8'hFF, 8'h00, 0, 16'h0000, 16'h0000);
    add_row(REQ_RESOLVE, 16'h0000, 8'h00, MODE_ZPY,   8'h00, 8'h80, 0, 16'h0000, 16'h0000);
    add_row(REQ_SET_PC,  16'h0100, 8'h00, MODE_IMM,   8'h00, 8'h00, 1, 16'h0000, 16'h0100);
    // pointer at the last zero page byte takes its high byte from address zero
    add_row(REQ_RESOLVE, 16'h0000, 8'h00, MODE_INDY,  8'h00, 8'hFF, 0, 16'h0000, 16'h0000);
    add_row(REQ_RESOLVE, 16'h0000, 8'h00, MODE_INDX,  8'h7F, 8'h00, 0, 16'h0000, 16'h0000);
    add_row(REQ_RESOLVE, 16'h0000, 8'h00, MODE_ABSX,  8'hFF, 8'h00, 0, 16'h0000, 16'h0000);
    add_row(REQ_SET_PC,  16'hFFFF, 8'h00, MODE_IMM,   8'h00, 8'h00, 1, 16'h0000, 16'hFFFF);
    add_row(REQ_RESOLVE, 16'h0000, 8'h00, MODE_ABSY,  8'h00, 8'hFF, 0, 16'h0000, 16'h0000);

    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    while (requests_taken < dir_rows.size() + RANDOM_REQUESTS) begin
      pick = $urandom_range(0, 99);
      r    = random_request();
      if (pick < 65) begin
        // small program: operand bytes at the counter, pointer bytes, then resolve
        if ($urandom_range(0, 7) == 0) begin
          r.req_type    = REQ_SET_PC;
          r.target_addr = pick_addr();
          send_request(r);
        end
        md = 4'(($urandom_range(0, 19) == 0) ? $urandom_range(12, 15)
                                             : $urandom_range(MODE_IMM, MODE_IMPL));
        lo   = pick_byte();
        hi   = pick_byte();
        x    = pick_byte();
        y    = pick_byte();
        base = pc_shadow;
        put_byte(base, lo);
        put_byte(base + 16'd1, hi);
        case (md)
          MODE_INDX, MODE_INDY: begin
            p = (md == MODE_INDX) ? lo + x : lo;
            put_byte({8'h00, p}, pick_byte());
            put_byte({8'h00, p + 8'd1}, pick_byte());
          end
          MODE_IND: begin
            q = {hi, lo};
            put_byte(q, pick_byte());
            put_byte(q + 16'd1, pick_byte());
          end
          default: ;
        endcase
        r            = random_request();
        r.req_type   = REQ_RESOLVE;
        r.mode       = md;
        r.index_x    = x;
        r.index_y    = y;
        send_request(r);
      end else if (pick < 85) begin
        r.req_type    = REQ_WRITE;
        r.target_addr = pick_addr();
        send_request(r);
      end else if (pick < 92) begin
        r.req_type    = REQ_SET_PC;
        r.target_addr = pick_addr();
        send_request(r);
      end else if (pick < 97) begin
        r.req_type = REQ_RESOLVE;
        send_request(r);
      end else begin
        r.req_type = REQ_NONE;
        send_request(r);
      end
    end

    @(negedge clk);
    req_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS operand_address_resolver");
    end else begin
      $display("FAIL operand_address_resolver");
    end
    $finish;
  end

  // receiver: segments of always-ready, coin-toss, periodic and mostly-stalled,
  // plus one long hold-off so the block backs up into its request side
  initial begin : receiver
    int  seg_left;
    int  seg_mode;
    int  period;
    int  phase;
    bit  held_off;
    seg_left = 0;
    seg_mode = 0;
    period   = 2;
    phase    = 0;
    held_off = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (!held_off && results_seen >= 400) begin
        held_off  = 1'b1;
        res_ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      if (seg_left == 0) begin
        seg_mode = $urandom_range(0, 3);
        seg_left = $urandom_range(20, 300);
        period   = $urandom_range(2, 5);
      end
      seg_left--;
      phase++;
      case (seg_mode)
        0:       res_ready = 1'b1;
        1:       res_ready = 1'($urandom_range(0, 1));
        2:       res_ready = (phase % period == 0);
        default: res_ready = ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && res_valid && res_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", res_data.operand_addr, 16'h0000);
      end else begin
        want = pending_results.pop_front();
        if (res_data.operand_addr !== want.operand_addr)
          report_mismatch("operand_addr", res_data.operand_addr, want.operand_addr);
        if (res_data.next_pc !== want.next_pc)
          report_mismatch("next_pc", res_data.next_pc, want.next_pc);
      end
    end
  end

  // covers the memory clearing sweep after reset with ample margin
  initial begin : watchdog
    #1_500_000;
    $display("FAIL operand_address_resolver");
    $finish;
  end

endmodule
